[src/itok_pkg.sv]
`default_nettype none

package itok_pkg;

	localparam int NUMBER_BITS_DEF = 32;
	localparam int NAME_CHARS_DEF  = 3;

	localparam int TYPE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int NAME_W  = 24;
	localparam int NLEN_W  = 2;
	localparam int CHAR_W  = 8;

	localparam logic [TYPE_W-1:0] TOK_VAR  = 3'd0;
	localparam logic [TYPE_W-1:0] TOK_LPAR = 3'd1;
	localparam logic [TYPE_W-1:0] TOK_RPAR = 3'd2;
	localparam logic [TYPE_W-1:0] TOK_NAME = 3'd3;
	localparam logic [TYPE_W-1:0] TOK_NUM  = 3'd4;
	localparam logic [TYPE_W-1:0] TOK_OP   = 3'd5;

	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

	typedef struct packed {
		logic [TYPE_W-1:0]  token_type;
		logic [VALUE_W-1:0] number_value;
		logic               number_saturated;
		logic [NAME_W-1:0]  name_chars;
		logic [NLEN_W-1:0]  name_length;
		logic [CHAR_W-1:0]  operator_char;
		logic               last_of_run;
		logic               equation_done;
	} tok_t;

endpackage

`default_nettype wire

[src/infix_expression_tokenizer_core.sv]
`default_nettype none

// channel   valid        stall        payload
// input     char_valid   char_stall   char_code, end_of_equation
// output    token_valid  token_stall  token_type, number_value, number_saturated,
//                                     name_chars, name_length, operator_char,
//                                     last_of_run, equation_done
//
// an item goes into an input register, is tokenized there and its first token
// lands in the output register
// one item per cycle while token_stall is low; an item that gives two tokens holds
// the input register while the second token moves from the spill register
// arst_n clears the scan state and all valid flags
// token_stall holds the output register and, through it, char_stall

module infix_expression_tokenizer_core #(
	parameter int NUMBER_BITS = itok_pkg::NUMBER_BITS_DEF,
	parameter int NAME_CHARS  = itok_pkg::NAME_CHARS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        char_valid,
	output logic                             char_stall,
	input  wire logic [itok_pkg::CHAR_W-1:0] char_code,
	input  wire logic                        end_of_equation,
	output logic                             token_valid,
	input  wire logic                        token_stall,
	output logic [itok_pkg::TYPE_W-1:0]      token_type,
	output logic [itok_pkg::VALUE_W-1:0]     number_value,
	output logic                             number_saturated,
	output logic [itok_pkg::NAME_W-1:0]      name_chars,
	output logic [itok_pkg::NLEN_W-1:0]      name_length,
	output logic [itok_pkg::CHAR_W-1:0]      operator_char,
	output logic                             last_of_run,
	output logic                             equation_done
);
	import itok_pkg::*;

	localparam int NW   = NAME_CHARS * 8;
	localparam int CW   = $clog2(NAME_CHARS + 1);
	localparam int VXW  = (NUMBER_BITS > VALUE_W) ? NUMBER_BITS : VALUE_W;
	localparam int NXW  = (NW > NAME_W) ? NW : NAME_W;
	localparam int CXW  = (CW > NLEN_W) ? CW : NLEN_W;
	localparam int PW   = NUMBER_BITS + 4;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_NAME = 2'd2;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;

	// scan state
	logic [1:0]             mode_q;
	logic [NUMBER_BITS-1:0] acc_q;
	logic                   ovf_q;
	logic [NW-1:0]          nbuf_q;
	logic [CW-1:0]          ncnt_q;

	tok_t out_q;
	logic out_valid_q;
	tok_t spill_q;
	logic spill_valid_q;

	logic out_free;
	logic go;

	assign out_free   = !out_valid_q || !token_stall;
	assign go         = valid_s1 && !spill_valid_q && out_free;
	assign char_stall = valid_s1 && !go;

	// character classes
	logic is_digit, is_letter, is_blank;
	logic [3:0] dval;

	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_letter = ((char_s1 >= CH_LA) && (char_s1 <= CH_LZ)) ||
	                   ((char_s1 >= CH_UA) && (char_s1 <= CH_UZ));
	assign is_blank  = (char_s1 == CH_SPACE) || ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR));
	assign dval      = char_s1[3:0];

	// acc * 10 + digit, saturating
	logic [PW-1:0]          prod;
	logic                   acc_ovf;
	logic [NUMBER_BITS-1:0] acc_add;

	assign prod    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + PW'(dval);
	assign acc_ovf = ovf_q || (|prod[PW-1:NUMBER_BITS]);
	assign acc_add = acc_ovf ? {NUMBER_BITS{1'b1}} : prod[NUMBER_BITS-1:0];

	// next character into the pending name
	logic [NW-1:0] nbuf_add;
	logic [CW-1:0] ncnt_add;

	always_comb begin
		nbuf_add = nbuf_q;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (ncnt_q == CW'(i)) begin
				nbuf_add[(NAME_CHARS - 1 - i) * 8 +: 8] = char_s1;
			end
		end
		ncnt_add = (ncnt_q < CW'(NAME_CHARS)) ? ncnt_q + CW'(1) : ncnt_q;
	end

	// token formatting
	function automatic tok_t num_tok(input logic [NUMBER_BITS-1:0] v, input logic sat);
		logic [VXW-1:0] vx;
		tok_t t;
		vx = VXW'(v);
		t = '0;
		t.token_type       = TOK_NUM;
		t.number_value     = vx[VALUE_W-1:0];
		t.number_saturated = sat;
		return t;
	endfunction

	function automatic tok_t name_tok(input logic [NW-1:0] nb, input logic [CW-1:0] nc);
		logic [NXW-1:0] nx;
		logic [CXW-1:0] cx;
		tok_t t;
		nx = NXW'(nb);
		cx = CXW'(nc);
		t = '0;
		t.token_type  = TOK_NAME;
		t.name_chars  = nx[NAME_W-1:0];
		t.name_length = cx[NLEN_W-1:0];
		return t;
	endfunction

	// tokenizing of the item in the input register
	logic                   pre_v, cls_v;
	tok_t                   pre_tok, cls_tok;
	logic [1:0]             mode_d;
	logic [NUMBER_BITS-1:0] acc_d;
	logic                   ovf_d;
	logic [NW-1:0]          nbuf_d;
	logic [CW-1:0]          ncnt_d;
	logic                   classify;
	logic [NW-1:0]          nbuf_first;

	always_comb begin
		pre_v    = 1'b0;
		cls_v    = 1'b0;
		pre_tok  = '0;
		cls_tok  = '0;
		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		nbuf_d   = nbuf_q;
		ncnt_d   = ncnt_q;
		classify = 1'b1;
		nbuf_first = '0;
		nbuf_first[NW-1 -: 8] = char_s1;

		unique case (mode_q)
			MODE_NAME: begin
				classify = 1'b0;
				if (ncnt_add >= CW'(NAME_CHARS) || end_s1) begin
					pre_v   = 1'b1;
					pre_tok = name_tok(nbuf_add, ncnt_add);
					mode_d  = MODE_IDLE;
					nbuf_d  = '0;
					ncnt_d  = '0;
				end else begin
					nbuf_d = nbuf_add;
					ncnt_d = ncnt_add;
				end
			end
			MODE_NUM: begin
				if (is_digit) begin
					classify = 1'b0;
					if (end_s1) begin
						pre_v   = 1'b1;
						pre_tok = num_tok(acc_add, acc_ovf);
					end else begin
						acc_d = acc_add;
						ovf_d = acc_ovf;
					end
				end else begin
					pre_v   = 1'b1;
					pre_tok = num_tok(acc_q, ovf_q);
					acc_d   = '0;
					ovf_d   = 1'b0;
					mode_d  = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		if (classify) begin
			if (char_s1 == CH_X) begin
				cls_v = 1'b1;
				cls_tok.token_type = TOK_VAR;
			end else if (char_s1 == CH_LPAR) begin
				cls_v = 1'b1;
				cls_tok.token_type = TOK_LPAR;
			end else if (char_s1 == CH_RPAR) begin
				cls_v = 1'b1;
				cls_tok.token_type = TOK_RPAR;
			end else if (is_letter) begin
				if (NAME_CHARS <= 1 || end_s1) begin
					cls_v   = 1'b1;
					cls_tok = name_tok(nbuf_first, CW'(1));
					nbuf_d  = '0;
					ncnt_d  = '0;
				end else begin
					nbuf_d = nbuf_first;
					ncnt_d = CW'(1);
					mode_d = MODE_NAME;
				end
			end else if (is_digit) begin
				// a single digit never overflows
				if (end_s1) begin
					cls_v   = 1'b1;
					cls_tok = num_tok(NUMBER_BITS'(dval), 1'b0);
				end else begin
					acc_d  = NUMBER_BITS'(dval);
					ovf_d  = 1'b0;
					mode_d = MODE_NUM;
				end
			end else if (!is_blank) begin
				cls_v = 1'b1;
				cls_tok.token_type    = TOK_OP;
				cls_tok.operator_char = char_s1;
			end
		end

		if (end_s1) begin
			mode_d = MODE_IDLE;
			acc_d  = '0;
			ovf_d  = 1'b0;
			nbuf_d = '0;
			ncnt_d = '0;
		end
	end

	// place the one or two tokens of the item
	tok_t r0, r1;
	logic two;

	always_comb begin
		two = pre_v && cls_v;
		r0  = pre_v ? pre_tok : cls_tok;
		r1  = cls_tok;
		if (two) begin
			r1.last_of_run   = 1'b1;
			r1.equation_done = end_s1;
		end else begin
			r0.last_of_run   = 1'b1;
			r0.equation_done = end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			end_s1  <= end_of_equation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			nbuf_q <= '0;
			ncnt_q <= '0;
		end else if (go) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			ovf_q  <= ovf_d;
			nbuf_q <= nbuf_d;
			ncnt_q <= ncnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spill_valid_q <= 1'b0;
		end else if (out_free) begin
			if (spill_valid_q) begin
				out_valid_q   <= 1'b1;
				spill_valid_q <= 1'b0;
			end else if (go) begin
				out_valid_q   <= pre_v || cls_v;
				spill_valid_q <= two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (spill_valid_q) begin
				out_q <= spill_q;
			end else if (go) begin
				out_q   <= r0;
				spill_q <= r1;
			end
		end
	end

	assign token_valid      = out_valid_q;
	assign token_type       = out_q.token_type;
	assign number_value     = out_q.number_value;
	assign number_saturated = out_q.number_saturated;
	assign name_chars       = out_q.name_chars;
	assign name_length      = out_q.name_length;
	assign operator_char    = out_q.operator_char;
	assign last_of_run      = out_q.last_of_run;
	assign equation_done    = out_q.equation_done;

endmodule

`default_nettype wire

[src/itok_checker.sv]
`default_nettype none

module itok_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        token_valid,
	input wire logic                        token_stall,
	input wire logic [itok_pkg::TYPE_W-1:0] token_type,
	input wire logic [itok_pkg::VALUE_W-1:0] number_value,
	input wire logic                        number_saturated,
	input wire logic [itok_pkg::NAME_W-1:0] name_chars,
	input wire logic [itok_pkg::NLEN_W-1:0] name_length,
	input wire logic [itok_pkg::CHAR_W-1:0] operator_char,
	input wire logic                        last_of_run,
	input wire logic                        equation_done
);
	import itok_pkg::*;

	// a stalled token stays and holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_type) &&
		$stable(number_value) && $stable(name_chars) && $stable(operator_char) &&
		$stable(last_of_run) && $stable(equation_done))
		else $error("stalled token changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && equation_done |-> last_of_run)
		else $error("equation end not on last token of item");

	a_num_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_type != TOK_NUM |-> number_value == '0 && !number_saturated)
		else $error("number fields set on non-number token");

	a_name_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_type != TOK_NAME |-> name_chars == '0 && name_length == '0)
		else $error("name fields set on non-name token");

	a_op_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_type != TOK_OP |-> operator_char == '0)
		else $error("operator char set on non-operator token");

endmodule

bind infix_expression_tokenizer_core itok_checker u_itok_checker (.*);

`default_nettype wire
